### design/rbnp_pkg.sv
`default_nettype none
package rbnp_pkg;

  localparam int unsigned CoordBits = 20;
  localparam int unsigned DirBits   = 16;
  localparam int unsigned KindBits  = 3;
  localparam int unsigned IndexBits = 10;
  localparam int unsigned DistBits  = 32;
  // box bounds are two bits wider than coordinates, differences one more
  localparam int unsigned BndBits   = CoordBits + 2;
  localparam int unsigned DiffBits  = BndBits + 1;
  // quotient of a diff scaled by 2^22 over a 16-bit divisor
  localparam int unsigned NumBits   = DiffBits + 22;
  localparam int unsigned QCntBits  = 6;

  localparam logic [DistBits-1:0] DistMax = '1;

  typedef enum logic [2:0] {
    KIND_BOX    = 3'd0,
    KIND_ZONE   = 3'd1,
    KIND_ITEM   = 3'd2,
    KIND_ENEMY  = 3'd3,
    KIND_SPAWN  = 3'd4,
    KIND_LIGHT  = 3'd5,
    KIND_CAMERA = 3'd6,
    KIND_NONE   = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    REG_PERSON_HALF  = 3'd0,
    REG_THING_HALF   = 3'd1,
    REG_ITEM_CENTER  = 3'd2,
    REG_PERSON_CENTER = 3'd3,
    REG_PLATE_PAD    = 3'd4,
    REG_ZONE_FLOOR   = 3'd5
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                        mode;
    logic [KindBits-1:0]         obj_kind;
    logic [IndexBits-1:0]        obj_index;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] az;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by;
    logic signed [CoordBits-1:0] bz;
    logic                        last_candidate;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic [KindBits-1:0]  picked_kind;
    logic [IndexBits-1:0] picked_index;
    logic [DistBits-1:0]  hit_distance;
  } out_t;

  // divider control: start with operands, done with truncated quotient
  typedef struct packed {
    logic                       start;
    logic signed [DiffBits-1:0] num;
    logic signed [DirBits-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [NumBits-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

### design/rbnp_div.sv
`default_nettype none
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
module rbnp_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rbnp_pkg::div_req_t req_i,
  output rbnp_pkg::div_rsp_t      rsp_o
);
  import rbnp_pkg::*;

  localparam int unsigned MagBits = NumBits - 1;

  logic [MagBits-1:0]  num_q, num_d;
  logic [DirBits-1:0]  den_q, den_d;
  logic [DirBits:0]    rem_q, rem_d;
  logic                neg_q, neg_d;
  logic [QCntBits-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [DiffBits-1:0] num_abs;
  logic [DirBits-1:0]  den_abs;
  logic [DirBits+1:0]  trial;
  logic [DirBits:0]    shifted;

  always_comb begin
    num_abs = req_i.num[DiffBits-1] ? DiffBits'(-req_i.num) : DiffBits'(req_i.num);
    den_abs = req_i.den[DirBits-1] ? DirBits'(-req_i.den) : DirBits'(req_i.den);
    shifted = {rem_q[DirBits-1:0], num_q[MagBits-1]};
    trial   = {1'b0, shifted} - {2'b00, den_q};
  end

  // load operands or shift one quotient bit in
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = {num_abs[DiffBits-2:0], 22'd0};
      den_d  = den_abs;
      rem_d  = '0;
      neg_d  = req_i.num[DiffBits-1] ^ req_i.den[DirBits-1];
      cnt_d  = QCntBits'(MagBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DirBits+1]) begin
        rem_d = trial[DirBits:0];
        num_d = {num_q[MagBits-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        num_d = {num_q[MagBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == QCntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule
`default_nettype wire

### design/ray_box_nearest_pick.sv
`default_nettype none
// Nearest ray/box picker. Send a ray transaction (mode 0), then candidate
// transactions (mode 1); the one marked last_candidate yields one result with
// the first strictly nearest hit. A candidate's six slab distances are
// computed one after another by a single bit-serial divider; axes with a
// zero direction skip the divider. in_stall_o is high while a candidate is
// in work; a last candidate also waits in its final step while the
// previous result is still held on the output. Registers are to be written
// through the cfg port only while idle; the block does not enforce this.
module ray_box_nearest_pick (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire rbnp_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output rbnp_pkg::out_t       out_data_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [15:0]     cfg_data_i
);
  import rbnp_pkg::*;

  localparam int unsigned TBits = NumBits + 1;

  function automatic logic signed [DirBits-1:0] sat16(input logic signed [CoordBits-1:0] v);
    if (v > CoordBits'(32767)) return 16'sh7fff;
    if (v < -CoordBits'(32768)) return 16'sh8000;
    return DirBits'(v);
  endfunction

  function automatic logic [DistBits-1:0] tsat(input logic signed [TBits-1:0] v);
    if (v > TBits'(DistMax)) return DistMax;
    return DistBits'(v);
  endfunction

  // configuration
  logic [11:0]        person_half_q, thing_half_q;
  logic signed [15:0] item_center_q, person_center_q, zone_floor_q;
  logic [7:0]         plate_pad_q;

  // ray and best hit
  logic signed [CoordBits-1:0] org_q [3];
  logic signed [DirBits-1:0]   dir_q [3];
  logic [DistBits-1:0]  best_dist_q;
  logic [KindBits-1:0]  best_kind_q;
  logic [IndexBits-1:0] best_index_q;
  logic                 best_found_q;

  // candidate
  logic signed [BndBits-1:0] lo_q [3];
  logic signed [BndBits-1:0] hi_q [3];
  logic [KindBits-1:0]  kind_q;
  logic [IndexBits-1:0] idx_q;
  logic                 last_q, valid_cand_q, miss_q, side_q;
  logic [1:0]           axis_q;
  logic signed [TBits-1:0] t0_q, t1_q, ta_q;
  logic                 div_busy_q;
  out_t                 out_q;
  logic                 out_valid_q;

  state_e state_q, state_d;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc;
  logic emit_go;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign emit_go     = (state_q == ST_EMIT) && !(out_valid_q && out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  rbnp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // per-axis operands
  logic signed [CoordBits-1:0] cur_o;
  logic signed [DirBits-1:0]   cur_d;
  logic signed [BndBits-1:0]   cur_lo, cur_hi;
  logic signed [TBits-1:0]     qa, qb, qmin, qmax, nt0, nt1;
  always_comb begin
    cur_o  = org_q[axis_q];
    cur_d  = dir_q[axis_q];
    cur_lo = lo_q[axis_q];
    cur_hi = hi_q[axis_q];
    div_req.start = (state_q == ST_DIV) && !div_busy_q && (cur_d != '0) && !miss_q &&
                    valid_cand_q;
    div_req.num = side_q ? (DiffBits'(cur_hi) - DiffBits'(cur_o))
                         : (DiffBits'(cur_lo) - DiffBits'(cur_o));
    div_req.den = cur_d;
    qa   = ta_q;
    qb   = TBits'(div_rsp.quo);
    qmin = (qa > qb) ? qb : qa;
    qmax = (qa > qb) ? qa : qb;
    nt0  = (qmin > t0_q) ? qmin : t0_q;
    nt1  = (qmax < t1_q) ? qmax : t1_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = in_data_i.mode ? ST_SETUP : ST_IDLE;
      ST_SETUP:  state_d = ST_DIV;
      ST_DIV: begin
        if (miss_q || !valid_cand_q) state_d = ST_UPDATE;
        else if (cur_d == '0 || (div_rsp.done && side_q))
          if (axis_q == 2'd2) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:   state_d = emit_go ? ST_IDLE : ST_EMIT;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      person_half_q <= 12'd320;
      thing_half_q <= 12'd240;
      item_center_q <= -16'sd620;
      person_center_q <= -16'sd1400;
      plate_pad_q  <= 8'd8;
      zone_floor_q <= -16'sd260;
      for (int k = 0; k < 3; k++) begin
        org_q[k] <= '0;
        dir_q[k] <= '0;
      end
      best_dist_q  <= DistMax;
      best_kind_q  <= '0;
      best_index_q <= '0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      div_busy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // write registers
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PERSON_HALF:   person_half_q   <= cfg_data_i[11:0];
          REG_THING_HALF:    thing_half_q    <= cfg_data_i[11:0];
          REG_ITEM_CENTER:   item_center_q   <= cfg_data_i;
          REG_PERSON_CENTER: person_center_q <= cfg_data_i;
          REG_PLATE_PAD:     plate_pad_q     <= cfg_data_i[7:0];
          REG_ZONE_FLOOR:    zone_floor_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      // load ray
      if (in_acc && !in_data_i.mode) begin
        org_q[0] <= in_data_i.ax;
        org_q[1] <= in_data_i.ay;
        org_q[2] <= in_data_i.az;
        dir_q[0] <= sat16(in_data_i.bx);
        dir_q[1] <= sat16(in_data_i.by);
        dir_q[2] <= sat16(in_data_i.bz);
        best_dist_q  <= DistMax;
        best_kind_q  <= '0;
        best_index_q <= '0;
        best_found_q <= 1'b0;
      end
      if (div_req.start) div_busy_q <= 1'b1;
      else if (div_rsp.done) div_busy_q <= 1'b0;
      // keep strictly nearer hit
      if (state_q == ST_UPDATE && valid_cand_q && !miss_q) begin
        if (!best_found_q || tsat(t0_q) < best_dist_q) begin
          best_found_q <= 1'b1;
          best_dist_q  <= tsat(t0_q);
          best_kind_q  <= kind_q;
          best_index_q <= idx_q;
        end
      end
      if (emit_go) begin
        out_valid_q  <= 1'b1;
        best_dist_q  <= DistMax;
        best_kind_q  <= '0;
        best_index_q <= '0;
        best_found_q <= 1'b0;
      end
    end
  end

  // emitted payload
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_q.found        <= best_found_q;
      out_q.picked_kind  <= best_kind_q;
      out_q.picked_index <= best_index_q;
      out_q.hit_distance <= best_dist_q;
    end
  end

  // candidate box and slab sequencing
  logic signed [BndBits-1:0] cy, hh;
  always_comb begin
    case (in_data_i.obj_kind)
      KIND_ITEM:                cy = BndBits'(item_center_q);
      KIND_ENEMY, KIND_SPAWN:   cy = BndBits'(person_center_q);
      default:                  cy = BndBits'(in_data_i.ay);
    endcase
    hh = (in_data_i.obj_kind == KIND_ENEMY || in_data_i.obj_kind == KIND_SPAWN)
       ? BndBits'($signed({1'b0, person_half_q})) : BndBits'($signed({1'b0, thing_half_q}));
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.mode) begin
      kind_q <= in_data_i.obj_kind;
      idx_q  <= in_data_i.obj_index;
      last_q <= in_data_i.last_candidate;
      valid_cand_q <= (in_data_i.obj_kind != KIND_NONE);
      case (in_data_i.obj_kind)
        KIND_BOX: begin
          lo_q[0] <= BndBits'(in_data_i.ax);
          hi_q[0] <= BndBits'(in_data_i.bx);
          lo_q[2] <= BndBits'(in_data_i.az);
          hi_q[2] <= BndBits'(in_data_i.bz);
          if (in_data_i.ay == in_data_i.by) begin
            lo_q[1] <= BndBits'(in_data_i.ay) - BndBits'(plate_pad_q);
            hi_q[1] <= BndBits'(in_data_i.by) + BndBits'(plate_pad_q);
          end else begin
            lo_q[1] <= BndBits'(in_data_i.ay);
            hi_q[1] <= BndBits'(in_data_i.by);
          end
        end
        KIND_ZONE: begin
          lo_q[0] <= BndBits'((in_data_i.ax < in_data_i.bx) ? in_data_i.ax : in_data_i.bx);
          hi_q[0] <= BndBits'((in_data_i.ax < in_data_i.bx) ? in_data_i.bx : in_data_i.ax);
          lo_q[2] <= BndBits'((in_data_i.az < in_data_i.bz) ? in_data_i.az : in_data_i.bz);
          hi_q[2] <= BndBits'((in_data_i.az < in_data_i.bz) ? in_data_i.bz : in_data_i.az);
          lo_q[1] <= BndBits'(zone_floor_q);
          hi_q[1] <= '0;
        end
        default: begin
          lo_q[0] <= BndBits'(in_data_i.ax) - hh;
          hi_q[0] <= BndBits'(in_data_i.ax) + hh;
          lo_q[1] <= cy - hh;
          hi_q[1] <= cy + hh;
          lo_q[2] <= BndBits'(in_data_i.az) - hh;
          hi_q[2] <= BndBits'(in_data_i.az) + hh;
        end
      endcase
    end
    if (state_q == ST_SETUP) begin
      axis_q <= '0;
      side_q <= 1'b0;
      miss_q <= 1'b0;
      t0_q   <= '0;
      t1_q   <= {2'b00, {(TBits-2){1'b1}}};
    end else if (state_q == ST_DIV && valid_cand_q && !miss_q) begin
      if (cur_d == '0) begin
        // containment test on a flat axis
        if ((BndBits+1)'(cur_o) < (BndBits+1)'(cur_lo) ||
            (BndBits+1)'(cur_o) > (BndBits+1)'(cur_hi)) miss_q <= 1'b1;
        axis_q <= axis_q + 2'd1;
      end else if (div_rsp.done) begin
        if (!side_q) begin
          ta_q   <= qb;
          side_q <= 1'b1;
        end else begin
          t0_q   <= nt0;
          t1_q   <= nt1;
          if (nt0 > nt1) miss_q <= 1'b1;
          side_q <= 1'b0;
          axis_q <= axis_q + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire
